@@ sv/irts_pkg.sv @@
// ============================================================================
// irts_pkg: shared definitions for the three-shear image rotator
// Register indexes, request kinds, field widths and the frame size clamp.
// ============================================================================
package irts_pkg;

  // Pixel and configuration widths.
  localparam int unsigned PixW       = 32;
  localparam int unsigned ShearW     = 16;
  localparam int unsigned CfgSizeW   = 9;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = 16;

  // Default frame limits and the size registers' reset value.
  localparam int unsigned MaxWidthDef  = 256;
  localparam int unsigned MaxHeightDef = 256;
  localparam int unsigned SizeReset    = 256;

  // The shift is rounded from a product scaled by 2^15 (Q1.14 times 2*pos).
  localparam int unsigned SkewShift = 15;
  localparam int unsigned SkewHalf  = 16384;

  // Depth of the queue between the front and the back.
  localparam int unsigned QueueDepth = 4;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_SHEAR_X      = 2'd2,
    REG_SHEAR_Y      = 2'd3
  } reg_idx_e;

  // Request kinds carried on the input side band.
  typedef enum logic {
    ACT_LOAD = 1'b0,
    ACT_READ = 1'b1
  } action_e;

  // Shear factors handed from the register bank to the datapath.
  typedef struct packed {
    logic signed [ShearW-1:0] x;
    logic signed [ShearW-1:0] y;
  } shear_t;

  // Saturate a frame size register to 1..maxv.
  function automatic int unsigned clamp_size(input logic [CfgSizeW-1:0] v,
                                             input int unsigned maxv);
    int unsigned u;
    u = 32'(v);
    if (u == 0) begin
      return 1;
    end
    if (u > maxv) begin
      return maxv;
    end
    return u;
  endfunction

endpackage

@@ sv/irts_ram.sv @@
// ============================================================================
// irts_ram: generic single-port RAM
// One access per cycle, either a write or a read; read data is registered.
// ============================================================================
module irts_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] addr_i,
  input  logic [Width-1:0] wdata_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];

  // Write or registered read at a single address.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem[addr_i] <= wdata_i;
      end else begin
        rdata_o <= mem[addr_i];
      end
    end
  end

endmodule

@@ sv/irts_fifo.sv @@
// ============================================================================
// irts_fifo: small register queue
// Decouples the request front from the shear datapath.
// ============================================================================
module irts_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [Width-1:0] rdata_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] slot_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign rdata_o = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Pointer and fill bookkeeping.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Storage slots carry no reset.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

@@ sv/irts_front.sv @@
// ============================================================================
// irts_front: register bank and request front
// Holds the configuration, tracks load and read positions, and turns each
// accepted request into a queue entry for the shear datapath.
// ============================================================================
module irts_front #(
  parameter int unsigned MAX_WIDTH  = 256,
  parameter int unsigned MAX_HEIGHT = 256,
  localparam int unsigned XW   = $clog2(MAX_WIDTH),
  localparam int unsigned YW   = $clog2(MAX_HEIGHT),
  localparam int unsigned SWX  = $clog2(MAX_WIDTH + 1),
  localparam int unsigned SWY  = $clog2(MAX_HEIGHT + 1),
  localparam int unsigned AW   = $clog2(MAX_WIDTH * MAX_HEIGHT),
  localparam int unsigned EntW = 2 + XW + YW + AW + irts_pkg::PixW
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [irts_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [irts_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  logic                          s_tvalid_i,
  output logic                          s_tready_o,
  input  logic [irts_pkg::PixW-1:0]     s_tdata_i,
  input  logic                          s_tuser_i,
  output logic                          push_o,
  output logic [EntW-1:0]               entry_o,
  input  logic                          full_i,
  output irts_pkg::shear_t              shear_o,
  output logic [SWX-1:0]                eff_w_o,
  output logic [SWY-1:0]                eff_h_o
);

  import irts_pkg::*;

  localparam int unsigned PW   = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
  localparam int unsigned CntW = $clog2(PW);

  typedef struct packed {
    logic            is_read;
    logic            last;
    logic [XW-1:0]   x;
    logic [YW-1:0]   y;
    logic [AW-1:0]   addr;
    logic [PixW-1:0] pixel;
  } entry_t;

  typedef enum logic [3:0] {
    ST_SETTLE = 4'b0001,
    ST_CLAMP  = 4'b0010,
    ST_DIV    = 4'b0100,
    ST_RUN    = 4'b1000
  } state_e;

  state_e          state_q, state_d;
  logic [SWX-1:0]  eff_w_q;
  logic [SWY-1:0]  eff_h_q;
  shear_t          shear_q;
  logic [PW-1:0]   count_q, count_d;
  logic [PW-1:0]   ld_pos_q, ld_pos_d;
  logic [PW-1:0]   rd_pos_q, rd_pos_d;
  logic [XW-1:0]   rd_x_q, rd_x_d;
  logic [YW-1:0]   rd_y_q, rd_y_d;
  logic [PW-1:0]   dvd_q, dvd_d;
  logic [PW-1:0]   quo_q, quo_d;
  logic [SWX-1:0]  rem_q, rem_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [SWX:0]    rem_sh;
  logic            rem_ge;
  logic [SWX-1:0]  rem_next;
  logic [PW-1:0]   quo_next;
  logic            accept;
  logic            rd_last;
  logic            ld_last;
  entry_t          entry;

  assign s_tready_o = (state_q == ST_RUN) && !full_i;
  assign accept     = s_tvalid_i && s_tready_o;
  assign rd_last    = (rd_pos_q == count_q - PW'(1));
  assign ld_last    = (ld_pos_q == count_q - PW'(1));
  assign shear_o    = shear_q;
  assign eff_w_o    = eff_w_q;
  assign eff_h_o    = eff_h_q;

  // Configuration registers; sizes are stored already saturated.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eff_w_q <= SWX'(clamp_size(CfgSizeW'(SizeReset), MAX_WIDTH));
      eff_h_q <= SWY'(clamp_size(CfgSizeW'(SizeReset), MAX_HEIGHT));
      shear_q <= '0;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_FRAME_WIDTH: begin
          eff_w_q <= SWX'(clamp_size(cfg_wdata_i[CfgSizeW-1:0], MAX_WIDTH));
        end
        REG_FRAME_HEIGHT: begin
          eff_h_q <= SWY'(clamp_size(cfg_wdata_i[CfgSizeW-1:0], MAX_HEIGHT));
        end
        REG_SHEAR_X: begin
          shear_q.x <= $signed(cfg_wdata_i);
        end
        REG_SHEAR_Y: begin
          shear_q.y <= $signed(cfg_wdata_i);
        end
        default: begin
          shear_q <= shear_q;
        end
      endcase
    end
  end

  // One restoring division step for re-deriving the read coordinates.
  always_comb begin
    rem_sh   = {rem_q, dvd_q[PW-1]};
    rem_ge   = (rem_sh >= {1'b0, eff_w_q});
    rem_next = rem_ge ? SWX'(rem_sh - {1'b0, eff_w_q}) : SWX'(rem_sh);
    quo_next = {quo_q[PW-2:0], rem_ge};
  end

  // Position tracking: settle the pixel count, restart stale positions,
  // split the read position into column and row, then serve requests.
  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    ld_pos_d = ld_pos_q;
    rd_pos_d = rd_pos_q;
    rd_x_d   = rd_x_q;
    rd_y_d   = rd_y_q;
    dvd_d    = dvd_q;
    quo_d    = quo_q;
    rem_d    = rem_q;
    cnt_d    = cnt_q;
    unique case (state_q)
      ST_SETTLE: begin
        count_d = PW'(eff_w_q) * PW'(eff_h_q);
        state_d = ST_CLAMP;
      end
      ST_CLAMP: begin
        if (ld_pos_q >= count_q) begin
          ld_pos_d = '0;
        end
        if (rd_pos_q >= count_q) begin
          rd_pos_d = '0;
          rd_x_d   = '0;
          rd_y_d   = '0;
          state_d  = ST_RUN;
        end else begin
          dvd_d   = rd_pos_q;
          quo_d   = '0;
          rem_d   = '0;
          cnt_d   = CntW'(PW - 1);
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        dvd_d = {dvd_q[PW-2:0], 1'b0};
        quo_d = quo_next;
        rem_d = rem_next;
        cnt_d = cnt_q - CntW'(1);
        if (cnt_q == '0) begin
          rd_x_d  = XW'(rem_next);
          rd_y_d  = YW'(quo_next);
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        if (accept) begin
          if (action_e'(s_tuser_i) == ACT_READ) begin
            if (rd_last) begin
              rd_pos_d = '0;
              rd_x_d   = '0;
              rd_y_d   = '0;
            end else begin
              rd_pos_d = rd_pos_q + PW'(1);
              if (SWX'(rd_x_q) + SWX'(1) == eff_w_q) begin
                rd_x_d = '0;
                rd_y_d = rd_y_q + YW'(1);
              end else begin
                rd_x_d = rd_x_q + XW'(1);
              end
            end
          end else begin
            ld_pos_d = ld_last ? '0 : ld_pos_q + PW'(1);
          end
        end
      end
      default: begin
        state_d = ST_SETTLE;
      end
    endcase
    // Any register write re-derives the count and positions.
    if (cfg_we_i) begin
      state_d = ST_SETTLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_SETTLE;
      count_q  <= '0;
      ld_pos_q <= '0;
      rd_pos_q <= '0;
      rd_x_q   <= '0;
      rd_y_q   <= '0;
      cnt_q    <= '0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      ld_pos_q <= ld_pos_d;
      rd_pos_q <= rd_pos_d;
      rd_x_q   <= rd_x_d;
      rd_y_q   <= rd_y_d;
      cnt_q    <= cnt_d;
    end
  end

  // Divider working registers.
  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
  end

  // Queue entry for the accepted request.
  always_comb begin
    entry.is_read = (action_e'(s_tuser_i) == ACT_READ);
    entry.last    = rd_last;
    entry.x       = rd_x_q;
    entry.y       = rd_y_q;
    entry.addr    = AW'(ld_pos_q);
    entry.pixel   = s_tdata_i;
  end

  assign push_o  = accept;
  assign entry_o = entry;

  // While serving, both positions lie inside the frame.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_RUN |-> (rd_pos_q < count_q) && (ld_pos_q < count_q))
    else $error("position outside the frame while serving requests");

  // The read column stays inside the row.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_RUN |-> SWX'(rd_x_q) < eff_w_q)
    else $error("read column past the frame width");

  // A register write always forces the count to be recomputed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> state_q == ST_SETTLE)
    else $error("register write did not restart position settling");

endmodule

@@ sv/irts_back.sv @@
// ============================================================================
// irts_back: inverse three-shear datapath and frame store
// Undoes the three shears one multiply per stage, then writes or reads the
// frame store and drives the result register.
// ============================================================================
module irts_back #(
  parameter int unsigned MAX_WIDTH  = 256,
  parameter int unsigned MAX_HEIGHT = 256,
  localparam int unsigned XW   = $clog2(MAX_WIDTH),
  localparam int unsigned YW   = $clog2(MAX_HEIGHT),
  localparam int unsigned SWX  = $clog2(MAX_WIDTH + 1),
  localparam int unsigned SWY  = $clog2(MAX_HEIGHT + 1),
  localparam int unsigned AW   = $clog2(MAX_WIDTH * MAX_HEIGHT),
  localparam int unsigned EntW = 2 + XW + YW + AW + irts_pkg::PixW
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  irts_pkg::shear_t          shear_i,
  input  logic [SWX-1:0]            eff_w_i,
  input  logic [SWY-1:0]            eff_h_i,
  input  logic                      entry_valid_i,
  input  logic [EntW-1:0]           entry_i,
  output logic                      pop_o,
  output logic                      m_tvalid_o,
  input  logic                      m_tready_i,
  output logic [irts_pkg::PixW-1:0] m_tdata_o,
  output logic                      m_tlast_o
);

  import irts_pkg::*;

  localparam int unsigned MaxDim = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int unsigned CW     = $clog2(MaxDim) + 3;
  localparam int unsigned DW     = CW + 2;
  localparam int unsigned PRW    = ShearW + DW;

  typedef struct packed {
    logic            is_read;
    logic            last;
    logic [XW-1:0]   x;
    logic [YW-1:0]   y;
    logic [AW-1:0]   addr;
    logic [PixW-1:0] pixel;
  } entry_t;

  // round(p / 2^15), half away from zero.
  function automatic logic signed [CW-1:0] round_skew(input logic signed [PRW-1:0] p);
    logic [PRW-1:0] mag;
    logic [PRW-1:0] r;
    mag = p[PRW-1] ? $unsigned(-p) : $unsigned(p);
    r   = (mag + PRW'(SkewHalf)) >> SkewShift;
    return p[PRW-1] ? -$signed(CW'(r)) : $signed(CW'(r));
  endfunction

  entry_t                  head;
  logic                    adv;
  logic signed [DW-1:0]    diff_a, diff_b, diff_c;
  logic signed [CW-1:0]    x2_c, y1_c, x0_c;

  logic                    s1_v, s2_v, s3_v, s4_v, s5_v, s6_v, s7_v;
  entry_t                  s1_e, s2_e, s3_e, s4_e, s5_e, s6_e;
  logic signed [PRW-1:0]   s1_prod, s3_prod, s5_prod;
  logic signed [CW-1:0]    s2_x2, s3_x2, s4_x2, s5_x2;
  logic signed [CW-1:0]    s4_y1;
  logic [AW-1:0]           s5_yw;
  logic [AW-1:0]           s6_addr;
  logic                    s2_ok, s3_ok, s4_ok, s5_ok, s6_ok, s7_ok;
  logic                    s7_read, s7_last;
  logic [PixW-1:0]         ram_rdata;
  logic                    ram_en;
  logic                    out_v_q;
  logic [PixW-1:0]         out_pix_q;
  logic                    out_last_q;

  assign head  = entry_t'(entry_i);
  assign adv   = !out_v_q || m_tready_i;
  assign pop_o = adv && entry_valid_i;

  // Differences from the center, scaled by two.
  assign diff_a = DW'({head.y, 1'b0}) - DW'(eff_h_i);
  assign diff_b = {s2_x2[CW-1], s2_x2, 1'b0} - DW'(eff_w_i);
  assign diff_c = {s4_y1[CW-1], s4_y1, 1'b0} - DW'(eff_h_i);

  // Coordinates after undoing each shear.
  assign x2_c = $signed(CW'(s1_e.x)) - round_skew(s1_prod);
  assign y1_c = $signed(CW'(s3_e.y)) - round_skew(s3_prod);
  assign x0_c = s5_x2 - round_skew(s5_prod);

  // Pipeline valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
      s4_v <= 1'b0;
      s5_v <= 1'b0;
      s6_v <= 1'b0;
      s7_v <= 1'b0;
    end else if (adv) begin
      s1_v <= entry_valid_i;
      s2_v <= s1_v;
      s3_v <= s2_v;
      s4_v <= s3_v;
      s5_v <= s4_v;
      s6_v <= s5_v;
      s7_v <= s6_v;
    end
  end

  // Pipeline payload: one multiply, then one round-and-check, per shear.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      // Third shear: its skew depends on the destination row.
      s1_e    <= head;
      s1_prod <= PRW'(shear_i.x) * PRW'(diff_a);
      s2_e    <= s1_e;
      s2_x2   <= x2_c;
      s2_ok   <= !x2_c[CW-1] && (x2_c < $signed(CW'(eff_w_i)));
      // Second shear: its skew depends on the intermediate column.
      s3_e    <= s2_e;
      s3_x2   <= s2_x2;
      s3_ok   <= s2_ok;
      s3_prod <= PRW'(shear_i.y) * PRW'(diff_b);
      s4_e    <= s3_e;
      s4_x2   <= s3_x2;
      s4_y1   <= y1_c;
      s4_ok   <= s3_ok && !y1_c[CW-1] && (y1_c < $signed(CW'(eff_h_i)));
      // First shear, plus the row base of the store address.
      s5_e    <= s4_e;
      s5_x2   <= s4_x2;
      s5_ok   <= s4_ok;
      s5_prod <= PRW'(shear_i.x) * PRW'(diff_c);
      s5_yw   <= AW'($unsigned(s4_y1)) * AW'(eff_w_i);
      s6_e    <= s5_e;
      s6_ok   <= s5_ok && !x0_c[CW-1] && (x0_c < $signed(CW'(eff_w_i)));
      s6_addr <= s5_e.is_read ? s5_yw + AW'($unsigned(x0_c)) : s5_e.addr;
      // Store access stage.
      s7_read <= s6_e.is_read;
      s7_last <= s6_e.last;
      s7_ok   <= s6_ok;
    end
  end

  // Loads write the store, reads fetch the source pixel.
  assign ram_en = adv && s6_v;

  irts_ram #(
    .Width (PixW),
    .Depth (MAX_WIDTH * MAX_HEIGHT)
  ) u_frame_store (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (!s6_e.is_read),
    .addr_i  (s6_addr),
    .wdata_i (s6_e.pixel),
    .rdata_o (ram_rdata)
  );

  // Result register; a read that maps outside the frame returns zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (adv) begin
      out_v_q <= s7_v && s7_read;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_pix_q  <= s7_ok ? ram_rdata : '0;
      out_last_q <= s7_last;
    end
  end

  assign m_tvalid_o = out_v_q;
  assign m_tdata_o  = out_pix_q;
  assign m_tlast_o  = out_last_q;

  // A load reaching the end of the pipe never produces a result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && s7_v && !s7_read |=> !out_v_q)
    else $error("load request produced a result");

  // A new result always comes from a read request in the last stage.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_v_q) |-> $past(s7_v && s7_read))
    else $error("result without a read request");

  // The store is not touched while the pipeline is held.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |-> !ram_en)
    else $error("store accessed during a stall");

endmodule

@@ sv/image_rotate_three_shear.sv @@
// ============================================================================
// image_rotate_three_shear: frame rotator built from three pixel shears
// Load requests fill the frame store in raster order; read requests return
// the rotated frame in raster order, zero where no source pixel maps.
// ============================================================================
// The block takes one request per cycle at a sustained rate while results are
// taken as they come. A read result passes through the queue slot, the
// pipeline that undoes the three shears with one multiplier stage each, the
// single-port frame store and the result register. A queue of four entries
// sits between the input and that pipeline. While a result waits, the whole
// pipeline holds, and the queue takes up to four more requests before the
// input stalls. After each register write the input stalls while the pixel
// count is recomputed and the read position is split into column and row by a
// bit-serial divider; when the read position restarts at zero the divider is
// skipped. The frame store has no clearing pass; reading a pixel that was
// never loaded gives an unspecified value.
module image_rotate_three_shear #(
  parameter int unsigned MAX_WIDTH  = irts_pkg::MaxWidthDef,
  parameter int unsigned MAX_HEIGHT = irts_pkg::MaxHeightDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration writes.
  input  logic                          cfg_we_i,
  input  logic [irts_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [irts_pkg::CfgDataW-1:0] cfg_wdata_i,
  // Request stream.
  input  logic                          s_tvalid_i,
  output logic                          s_tready_o,
  input  logic [irts_pkg::PixW-1:0]     s_tdata_i,   // [31:0] pixel_in
  input  logic                          s_tuser_i,   // [0] action
  // Result stream.
  output logic                          m_tvalid_o,
  input  logic                          m_tready_i,
  output logic [irts_pkg::PixW-1:0]     m_tdata_o,   // [31:0] pixel_out
  output logic                          m_tlast_o
);

  import irts_pkg::*;

  localparam int unsigned XW   = $clog2(MAX_WIDTH);
  localparam int unsigned YW   = $clog2(MAX_HEIGHT);
  localparam int unsigned SWX  = $clog2(MAX_WIDTH + 1);
  localparam int unsigned SWY  = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned AW   = $clog2(MAX_WIDTH * MAX_HEIGHT);
  localparam int unsigned EntW = 2 + XW + YW + AW + PixW;

  logic            push;
  logic            full;
  logic            pop;
  logic            q_valid;
  logic [EntW-1:0] push_entry;
  logic [EntW-1:0] head_entry;
  shear_t          shear;
  logic [SWX-1:0]  eff_w;
  logic [SWY-1:0]  eff_h;

  // Register bank and request front.
  irts_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .s_tvalid_i  (s_tvalid_i),
    .s_tready_o  (s_tready_o),
    .s_tdata_i   (s_tdata_i),
    .s_tuser_i   (s_tuser_i),
    .push_o      (push),
    .entry_o     (push_entry),
    .full_i      (full),
    .shear_o     (shear),
    .eff_w_o     (eff_w),
    .eff_h_o     (eff_h)
  );

  // Request queue.
  irts_fifo #(
    .Width (EntW),
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_entry),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .rdata_o (head_entry)
  );

  // Shear datapath and frame store.
  irts_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .shear_i       (shear),
    .eff_w_i       (eff_w),
    .eff_h_i       (eff_h),
    .entry_valid_i (q_valid),
    .entry_i       (head_entry),
    .pop_o         (pop),
    .m_tvalid_o    (m_tvalid_o),
    .m_tready_i    (m_tready_i),
    .m_tdata_o     (m_tdata_o),
    .m_tlast_o     (m_tlast_o)
  );

endmodule

@@ tb/image_rotate_three_shear_test.sv @@
// ============================================================================
// image_rotate_three_shear_test: self-checking bench for the shear rotator
// Loads frames of many sizes, reads them back rotated under a range of shear
// settings and compares every returned pixel and its end-of-frame flag with
// a behavioral rotator kept inside the bench.
// ============================================================================
module image_rotate_three_shear_test;
  timeunit 1ns;
  timeprecision 1ps;

  import irts_pkg::*;

  localparam int unsigned CycleLimit   = 400000;
  localparam int unsigned SettleCycles = 24;
  localparam int unsigned ReportLimit  = 10;
  localparam int unsigned FrameMax     = 256;

  // One rotated pixel as the block should return it.
  typedef struct {
    logic [PixW-1:0] pixel;
    logic            last;
  } rotated_pixel_t;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i   = '0;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;
  logic                s_tvalid_i  = 1'b0;
  logic                s_tready_o;
  logic [PixW-1:0]     s_tdata_i   = '0;  // [31:0] pixel_in
  logic                s_tuser_i   = 1'b0; // [0] action
  logic                m_tvalid_o;
  logic                m_tready_i  = 1'b0;
  logic [PixW-1:0]     m_tdata_o;          // [31:0] pixel_out
  logic                m_tlast_o;

  // Bench copy of the frame store, positions and registers.
  logic [PixW-1:0]          shadow_frame [FrameMax*FrameMax];
  int unsigned              load_pos  = 0;
  int unsigned              read_pos  = 0;
  logic [CfgSizeW-1:0]      width_reg = 9'(SizeReset);
  logic [CfgSizeW-1:0]      height_reg = 9'(SizeReset);
  logic signed [ShearW-1:0] shear_x_reg = '0;
  logic signed [ShearW-1:0] shear_y_reg = '0;

  rotated_pixel_t rotated_pixel_q [$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned fail_count    = 0;
  int unsigned reads_checked = 0;
  int unsigned loads_sent    = 0;
  int unsigned cfg_writes    = 0;
  int unsigned cycle_count   = 0;

  image_rotate_three_shear i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .s_tvalid_i  (s_tvalid_i),
    .s_tready_o  (s_tready_o),
    .s_tdata_i   (s_tdata_i),
    .s_tuser_i   (s_tuser_i),
    .m_tvalid_o  (m_tvalid_o),
    .m_tready_i  (m_tready_i),
    .m_tdata_o   (m_tdata_o),
    .m_tlast_o   (m_tlast_o)
  );

  // Clock with a 2 ns period.
  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Give up if the run hangs.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("ERROR: timeout after %0d cycles, %0d reads pending", cycle_count,
               rotated_pixel_q.size());
      $display("simulation failed");
      $finish;
    end
  end

  // Frame size as the block uses it: saturated to 1..FrameMax.
  function automatic longint frame_dim(input logic [CfgSizeW-1:0] v);
    if (v == 0) begin
      return 1;
    end
    if (v > FrameMax) begin
      return FrameMax;
    end
    return longint'(v);
  endfunction

  // Whole-pixel shift of one shear: round(s / 2^14 * (p - n/2)), half away from zero.
  function automatic longint shear_shift(input logic signed [ShearW-1:0] s,
                                         input longint p, input longint n);
    longint prod;
    longint mag;
    longint r;
    prod = longint'(s) * (2 * p - n);
    mag  = (prod < 0) ? -prod : prod;
    r    = (mag + longint'(SkewHalf)) >>> SkewShift;
    return (prod < 0) ? -r : r;
  endfunction

  // Apply one accepted request to the bench rotator; reads queue a result.
  function automatic void track_rotation(input action_e act, input logic [PixW-1:0] pix);
    longint         w;
    longint         h;
    longint         cnt;
    longint         x;
    longint         y;
    longint         x2;
    longint         y1;
    longint         x0;
    rotated_pixel_t r;
    w   = frame_dim(width_reg);
    h   = frame_dim(height_reg);
    cnt = w * h;
    if (act == ACT_LOAD) begin
      if (load_pos >= cnt) begin
        load_pos = 0;
      end
      shadow_frame[load_pos] = pix;
      load_pos = (load_pos + 1 >= cnt) ? 0 : load_pos + 1;
      loads_sent++;
    end else begin
      if (read_pos >= cnt) begin
        read_pos = 0;
      end
      x = longint'(read_pos) % w;
      y = longint'(read_pos) / w;
      r.pixel = '0;
      // Walk back through the third, second and first shear.
      x2 = x - shear_shift(shear_x_reg, y, h);
      if (x2 >= 0 && x2 < w) begin
        y1 = y - shear_shift(shear_y_reg, x2, w);
        if (y1 >= 0 && y1 < h) begin
          x0 = x2 - shear_shift(shear_x_reg, y1, h);
          if (x0 >= 0 && x0 < w) begin
            r.pixel = shadow_frame[y1 * w + x0];
          end
        end
      end
      r.last = (read_pos == cnt - 1);
      rotated_pixel_q.push_back(r);
      read_pos = (read_pos + 1 >= cnt) ? 0 : read_pos + 1;
    end
  endfunction

  // Receiver: random back-pressure and a check of every returned pixel.
  always @(posedge clk_i) begin : check_results
    rotated_pixel_t want;
    if (rst_ni && m_tvalid_o && m_tready_i) begin
      if (rotated_pixel_q.size() == 0) begin
        fail_count++;
        if (fail_count <= ReportLimit) begin
          $display("ERROR: unexpected result pixel=%h last=%b", m_tdata_o, m_tlast_o);
        end
      end else begin
        want = rotated_pixel_q.pop_front();
        if (m_tdata_o !== want.pixel || m_tlast_o !== want.last) begin
          fail_count++;
          if (fail_count <= ReportLimit) begin
            $display("ERROR: read %0d expected pixel=%h last=%b, got pixel=%h last=%b",
                     reads_checked, want.pixel, want.last, m_tdata_o, m_tlast_o);
          end
        end
        reads_checked++;
      end
    end
    m_tready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Send one request; valid stays high afterwards unless a gap follows.
  task automatic send_request(input action_e act, input logic [PixW-1:0] pix);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      s_tvalid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    s_tvalid_i <= 1'b1;
    s_tuser_i  <= act;
    s_tdata_i  <= pix;
    do @(posedge clk_i); while (!s_tready_o);
    track_rotation(act, pix);
  endtask

  // Hold the request side until every pending read has returned.
  task automatic wait_drained();
    s_tvalid_i <= 1'b0;
    do @(posedge clk_i); while (rotated_pixel_q.size() != 0);
  endtask

  // Drain, then let any load still inside the pipeline settle.
  task automatic wait_idle();
    wait_drained();
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [CfgDataW-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    case (idx)
      REG_FRAME_WIDTH:  width_reg   = value[CfgSizeW-1:0];
      REG_FRAME_HEIGHT: height_reg  = value[CfgSizeW-1:0];
      REG_SHEAR_X:      shear_x_reg = value;
      REG_SHEAR_Y:      shear_y_reg = value;
      default: ;
    endcase
    cfg_writes++;
  endtask

  // Set all four registers while the block is idle.
  task automatic configure(input logic [CfgDataW-1:0] w, input logic [CfgDataW-1:0] h,
                           input logic [CfgDataW-1:0] sx, input logic [CfgDataW-1:0] sy);
    write_reg(REG_FRAME_WIDTH, w);
    write_reg(REG_FRAME_HEIGHT, h);
    write_reg(REG_SHEAR_X, sx);
    write_reg(REG_SHEAR_Y, sy);
    cfg_we_i <= 1'b0;
  endtask

  // Pixel values biased toward all zeros and all ones.
  function automatic logic [PixW-1:0] pick_pixel();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      default: return $urandom();
    endcase
  endfunction

  // Fill every pixel of the frame in use, so no read can reach a stale entry.
  task automatic load_frame();
    longint n;
    n = frame_dim(width_reg) * frame_dim(height_reg);
    repeat (n) send_request(ACT_LOAD, pick_pixel());
  endtask

  // One setting: configure, load the frame, then a random mix of reads and loads
  // with a full drain half way through.
  task automatic run_setting(input logic [CfgDataW-1:0] w, input logic [CfgDataW-1:0] h,
                             input logic [CfgDataW-1:0] sx, input logic [CfgDataW-1:0] sy,
                             input int unsigned ops);
    wait_idle();
    configure(w, h, sx, sy);
    load_frame();
    for (int unsigned i = 0; i < ops; i++) begin
      if (i == ops / 2) begin
        wait_drained();
      end
      if ($urandom_range(99) < 60) begin
        send_request(ACT_READ, $urandom());
      end else begin
        send_request(ACT_LOAD, pick_pixel());
      end
    end
  endtask

  // Unrotated 3x2 frame: extreme pixel values come back in place.
  task automatic test_identity_frame();
    configure(16'd3, 16'd2, 16'd0, 16'd0);
    send_request(ACT_LOAD, '0);
    send_request(ACT_LOAD, '1);
    repeat (4) send_request(ACT_LOAD, $urandom());
    repeat (4) send_request(ACT_READ, $urandom());
  endtask

  // Width zero saturates to one; the read position past the new frame restarts,
  // and a shear of 1.0 pushes the only pixel out, so reads return zero.
  task automatic test_size_shrink();
    wait_idle();
    configure(16'd0, 16'd1, 16'h4000, 16'd0);
    send_request(ACT_LOAD, $urandom());
    repeat (2) send_request(ACT_READ, '1);
  endtask

  // About 45 degrees on a small frame.
  task automatic test_rotate_45();
    run_setting(16'd8, 16'd6, 16'(-6786), 16'd11585, 40);
  endtask

  // Widest frame with shears at -1.0 and +1.0.
  task automatic test_wide_frame_full_shear();
    run_setting(16'h0100, 16'd1, 16'(-16384), 16'd16384, 30);
  endtask

  // Tallest frame; size registers carry junk high bits and oversize values,
  // shears sit at the ends of the 16-bit range.
  task automatic test_tall_frame_oversize_regs();
    run_setting(16'hFE01, 16'h01FF, 16'h7FFF, 16'h8000, 30);
  endtask

  // Small random frames with any 16-bit shear.
  task automatic test_random_settings();
    repeat (4) begin
      run_setting(16'($urandom_range(1, 8)), 16'($urandom_range(1, 8)),
                  16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)), 20);
    end
  endtask

  // Straight copy at full rate.
  task automatic test_identity_stream();
    run_setting(16'd6, 16'd5, 16'd0, 16'd0, 30);
  endtask

  // Shears within the legal -1.0..+1.0 range.
  task automatic test_moderate_shears();
    run_setting(16'($urandom_range(2, 8)), 16'($urandom_range(2, 8)),
                16'(int'($urandom_range(0, 32768)) - 16384),
                16'(int'($urandom_range(0, 32768)) - 16384), 30);
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 34;
    recv_idle_pct = 80;
    test_identity_frame();
    test_size_shrink();
    test_rotate_45();
    test_wide_frame_full_shear();

    send_idle_pct = 80;
    recv_idle_pct = 34;
    test_tall_frame_oversize_regs();
    test_random_settings();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_identity_stream();
    test_moderate_shears();

    wait_idle();
    $display("Checked %0d rotated reads after %0d loads and %0d register writes,",
             reads_checked, loads_sent, cfg_writes);
    $display("frames from 1x1 to 256 wide or tall, shears over the full signed range.");
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("simulation failed");
    end
    $finish;
  end

endmodule
